// ----- hw/rtl/fifo_queue_with_delete_assert.svh -----
// ----------------------------------------------------------------------------
// fifo_queue_with_delete assertion macros
// Clocked on clk_i, held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef FIFO_QUEUE_WITH_DELETE_ASSERT_SVH
`define FIFO_QUEUE_WITH_DELETE_ASSERT_SVH

// property must hold at every clock edge out of reset
`define FQD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define FQD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/fqd_pkg.sv -----
// ----------------------------------------------------------------------------
// fqd_pkg
// Sizes, types, request and status codes of the FIFO queue with delete.
// ----------------------------------------------------------------------------
package fqd_pkg;

  // store geometry
  localparam int Depth     = 16;
  localparam int DataWidth = 32;
  localparam int IdxW      = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW      = $clog2(Depth + 1);
  localparam int SumW      = CntW + 1;

  typedef logic [DataWidth-1:0] data_t;
  typedef logic [IdxW-1:0]      idx_t;
  typedef logic [CntW-1:0]      cnt_t;

  // request codes
  localparam logic [1:0] ReqEnq  = 2'd0;
  localparam logic [1:0] ReqDeq  = 2'd1;
  localparam logic [1:0] ReqDel  = 2'd2;
  localparam logic [1:0] ReqIter = 2'd3;

  // status codes
  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StZero  = 2'd1;
  localparam logic [1:0] StEmpty = 2'd2;
  localparam logic [1:0] StFull  = 2'd3;

  // memory port request from the controller
  typedef struct packed {
    logic  we;
    idx_t  waddr;
    data_t wdata;
    logic  re;
    idx_t  raddr;
  } mem_req_t;

  // request value as stored in the memory
  function automatic data_t to_data(logic [31:0] v);
    return DataWidth'(v);
  endfunction

  // physical entry at an offset from the head, wrapped once
  function automatic idx_t slot(idx_t head, cnt_t off);
    logic [SumW-1:0] sum;
    sum = SumW'(head) + SumW'(off);
    if (sum >= SumW'(Depth)) begin
      sum = sum - SumW'(Depth);
    end
    return IdxW'(sum);
  endfunction

endpackage

// ----- hw/rtl/fqd_if.sv -----
// ----------------------------------------------------------------------------
// fqd_req_if / fqd_rsp_if
// Valid/ready channels for requests into and results out of the queue.
// ----------------------------------------------------------------------------
interface fqd_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] item_value;

  modport source (output valid, output req_type, output item_value, input ready);
  modport sink   (input valid, input req_type, input item_value, output ready);
endinterface

interface fqd_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] value_out;
  logic        last;
  logic [4:0]  entry_count;

  modport source (output valid, output status, output value_out, output last,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input value_out, input last,
                  input entry_count, output ready);
endinterface

// ----- hw/rtl/fqd_ram.sv -----
// ----------------------------------------------------------------------------
// fqd_ram
// Simple dual-port RAM: one write, one read port, registered read data.
// Read data holds while no read is issued.
// ----------------------------------------------------------------------------
module fqd_ram #(
  parameter int Depth = 16,
  parameter int Width = 32,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/fqd_ctrl.sv -----
// ----------------------------------------------------------------------------
// fqd_ctrl
// Request sequencer: head and count, memory walks for delete and iterate,
// and the result register.
// ----------------------------------------------------------------------------
`include "fifo_queue_with_delete_assert.svh"

module fqd_ctrl import fqd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  fqd_req_if.sink         req_i,
  fqd_rsp_if.source       rsp_o,
  output mem_req_t        mem_o,
  input  data_t           mem_rdata_i
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;
  localparam logic [2:0] S_ITER   = 3'd5;

  logic [2:0]  state_q, state_d;
  logic [1:0]  type_q, type_d;
  data_t       val_q, val_d;
  cnt_t        off_q, off_d;
  idx_t        head_q, head_d;
  cnt_t        count_q, count_d;
  logic [1:0]  stat_q, stat_d;

  // result register
  logic        out_valid_q;
  logic [1:0]  out_status_q;
  logic [31:0] out_value_q;
  logic        out_last_q;
  logic [4:0]  out_count_q;

  logic        out_free;
  logic        out_load;
  logic [1:0]  o_status;
  logic [31:0] o_value;
  logic        o_last;

  logic        rd_en, wr_en;
  cnt_t        rd_off, wr_off;
  data_t       wr_data;
  cnt_t        off_nx;
  idx_t        head_nx;

  assign out_free = !out_valid_q || rsp_o.ready;
  assign off_nx   = off_q + CntW'(1);
  assign head_nx  = (head_q == IdxW'(Depth - 1)) ? '0 : head_q + IdxW'(1);
  assign req_i.ready = (state_q == S_IDLE);

  // sequencer
  always_comb begin
    state_d  = state_q;
    type_d   = type_q;
    val_d    = val_q;
    off_d    = off_q;
    head_d   = head_q;
    count_d  = count_q;
    stat_d   = stat_q;
    rd_en    = 1'b0;
    rd_off   = off_q;
    wr_en    = 1'b0;
    wr_off   = off_q;
    wr_data  = val_q;
    out_load = 1'b0;
    o_status = StOk;
    o_value  = '0;
    o_last   = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          type_d  = req_i.req_type;
          val_d   = to_data(req_i.item_value);
          off_d   = '0;
          rd_en   = 1'b1;
          rd_off  = '0;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (type_q)
          ReqEnq: begin
            if (out_free) begin
              out_load = 1'b1;
              state_d  = S_IDLE;
              if (val_q == '0) begin
                o_status = StZero;
              end else if (count_q == CntW'(Depth)) begin
                o_status = StFull;
              end else begin
                wr_en   = 1'b1;
                wr_off  = count_q;
                count_d = count_q + CntW'(1);
              end
            end
          end
          ReqDeq: begin
            if (out_free) begin
              out_load = 1'b1;
              state_d  = S_IDLE;
              if (count_q == '0) begin
                o_status = StEmpty;
              end else begin
                o_value = 32'(mem_rdata_i);
                head_d  = head_nx;
                count_d = count_q - CntW'(1);
              end
            end
          end
          ReqDel: begin
            if (val_q == '0 || count_q == '0) begin
              if (out_free) begin
                out_load = 1'b1;
                o_status = (val_q == '0) ? StZero : StEmpty;
                state_d  = S_IDLE;
              end
            end else begin
              state_d = S_SCAN;
            end
          end
          default: begin
            if (count_q == '0) begin
              if (out_free) begin
                out_load = 1'b1;
                o_status = StEmpty;
                state_d  = S_IDLE;
              end
            end else begin
              state_d = S_ITER;
            end
          end
        endcase
      end
      S_SCAN: begin
        // read data belongs to offset off_q
        if (mem_rdata_i == val_q) begin
          if (off_nx == count_q) begin
            count_d = count_q - CntW'(1);
            stat_d  = StOk;
            state_d = S_RESULT;
          end else begin
            rd_en   = 1'b1;
            rd_off  = off_nx;
            state_d = S_SHIFT;
          end
        end else if (off_nx == count_q) begin
          stat_d  = StEmpty;
          state_d = S_RESULT;
        end else begin
          off_d  = off_nx;
          rd_en  = 1'b1;
          rd_off = off_nx;
        end
      end
      S_SHIFT: begin
        // move entry off_q+1 down to off_q, fetch the one after it
        wr_en   = 1'b1;
        wr_off  = off_q;
        wr_data = mem_rdata_i;
        if (off_nx < count_q - CntW'(1)) begin
          rd_en  = 1'b1;
          rd_off = off_nx + CntW'(1);
          off_d  = off_nx;
        end else begin
          count_d = count_q - CntW'(1);
          stat_d  = StOk;
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          out_load = 1'b1;
          o_status = stat_q;
          state_d  = S_IDLE;
        end
      end
      S_ITER: begin
        if (out_free) begin
          out_load = 1'b1;
          o_value  = 32'(mem_rdata_i);
          o_last   = (off_nx == count_q);
          if (off_nx == count_q) begin
            state_d = S_IDLE;
          end else begin
            off_d  = off_nx;
            rd_en  = 1'b1;
            rd_off = off_nx;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // memory port
  assign mem_o.we    = wr_en;
  assign mem_o.waddr = slot(head_q, wr_off);
  assign mem_o.wdata = wr_data;
  assign mem_o.re    = rd_en;
  assign mem_o.raddr = slot(head_q, rd_off);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_load | (out_valid_q & ~rsp_o.ready);
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    type_q <= type_d;
    val_q  <= val_d;
    off_q  <= off_d;
    stat_q <= stat_d;
    if (out_load) begin
      out_status_q <= o_status;
      out_value_q  <= o_value;
      out_last_q   <= o_last;
      out_count_q  <= 5'(count_d);
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.value_out   = out_value_q;
  assign rsp_o.last        = out_last_q;
  assign rsp_o.entry_count = out_count_q;

  // checks
  `FQD_ASSERT_NEVER(a_rw_same_entry, mem_o.we && mem_o.re && (mem_o.waddr == mem_o.raddr), "read and write hit one entry")
  `FQD_ASSERT(a_count_bound, count_q <= CntW'(Depth), "count beyond depth")
  `FQD_ASSERT(a_count_busy, !$stable(count_q) |-> ($past(state_q) != S_IDLE), "count moved while idle")
  `FQD_ASSERT(a_iter_done, (out_load && o_last && (state_q == S_ITER)) |=> (state_q == S_IDLE), "iterate did not finish")

endmodule

// ----- hw/rtl/fifo_queue_with_delete.sv -----
// ----------------------------------------------------------------------------
// fifo_queue_with_delete
// Bounded FIFO of nonzero values with dequeue, delete by value and iterate.
//
//   channel  dir  fields                                   handshake
//   req_i    in   req_type, item_value                     valid/ready
//   rsp_o    out  status, value_out, last, entry_count     valid/ready
//
// One request at a time; the result register lets the next request in.
// Enqueue, dequeue and rejected requests: decode, then the result register.
// Delete: scan and shift states walk the stored entries, found or not; one
// memory read per cycle on the single read port paces this walk.
// Iterate: decode, then one entry per cycle while the result register is free.
// Reset clears head, count and control; entry contents are kept.
// A held result stalls an iterate walk in place and holds a finished delete in
// its result state; nothing is dropped.
module fifo_queue_with_delete import fqd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  fqd_req_if.sink   req_i,
  fqd_rsp_if.source rsp_o
);

  mem_req_t mem_req;
  data_t    mem_rdata;

  // sequencer
  fqd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .mem_o       (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  // entry store
  fqd_ram #(
    .Depth (Depth),
    .Width (DataWidth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench - FIFO queue with delete by value
// Drives enqueue, dequeue, delete and iterate requests through the valid/ready
// request channel, keeps its own model of the circular store, and compares
// every result field by field against the oldest predicted result. Sender
// bursts and receiver stall patterns vary throughout, with one long output
// stall that backs the block up onto its request channel.
// ----------------------------------------------------------------------------
module testbench;
  import fqd_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int HoldCycles    = 150;
  localparam int DrainCycles   = 40;
  localparam int MaxPrinted    = 50;

  // one result as predicted
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value_out;
    logic        last;
    logic [4:0]  entry_count;
  } queue_result_t;

  logic clk_i;
  logic rst_ni;

  fqd_req_if req_if ();
  fqd_rsp_if rsp_if ();

  fifo_queue_with_delete dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // shadow copy of the store
  data_t       queue_mem [Depth];
  int unsigned q_head  = 0;
  int unsigned q_count = 0;

  queue_result_t expected_results [$];

  int error_count     = 0;
  int results_checked = 0;
  int requests_seen [4];
  int hold_requests   = 0;
  int burst_left      = 0;
  bit sender_idles    = 1'b1;
  data_t value_pool [8];

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // one line per mismatch, printing capped
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= MaxPrinted) begin
      $display("[%0t] mismatch, %s: got 0x%0h, expected 0x%0h (result %0d)",
               $time, what, got, want, results_checked);
    end
  endtask

  // works out the results of one accepted request and updates the shadow store
  function automatic void predict_queue_request(input logic [1:0] kind,
                                                input logic [31:0] raw_value);
    data_t       value;
    int unsigned pos;
    queue_result_t r;
    value = data_t'(raw_value);
    requests_seen[kind]++;
    r.status      = StOk;
    r.value_out   = '0;
    r.last        = 1'b1;
    case (kind)
      ReqEnq: begin
        if (value == '0) begin
          r.status = StZero;
        end else if (q_count >= Depth) begin
          r.status = StFull;
        end else begin
          queue_mem[(q_head + q_count) % Depth] = value;
          q_count++;
        end
      end
      ReqDeq: begin
        if (q_count == 0) begin
          r.status = StEmpty;
        end else begin
          r.value_out = 32'(queue_mem[q_head]);
          q_head  = (q_head + 1) % Depth;
          q_count--;
        end
      end
      ReqDel: begin
        if (value == '0) begin
          r.status = StZero;
        end else begin
          pos = 0;
          while (pos < q_count && queue_mem[(q_head + pos) % Depth] != value) pos++;
          if (pos >= q_count) begin
            r.status = StEmpty;
          end else begin
            // close the gap: later entries move forward by one
            for (int j = pos; j + 1 < q_count; j++) begin
              queue_mem[(q_head + j) % Depth] = queue_mem[(q_head + j + 1) % Depth];
            end
            q_count--;
          end
        end
      end
      default: begin
        if (q_count == 0) begin
          r.status = StEmpty;
        end
      end
    endcase
    r.entry_count = 5'(q_count);
    if (kind == ReqIter && q_count != 0) begin
      // one result per stored entry, oldest first
      for (int i = 0; i < q_count; i++) begin
        r.value_out = 32'(queue_mem[(q_head + i) % Depth]);
        r.last      = (i + 1 == q_count);
        expected_results.push_back(r);
      end
    end else begin
      expected_results.push_back(r);
    end
  endfunction

  // result check first, then prediction of a request taken at the same edge
  always @(posedge clk_i) begin
    queue_result_t want;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        results_checked++;
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing pending", rsp_if.value_out, '0);
        end else begin
          want = expected_results.pop_front();
          if (rsp_if.status !== want.status)
            report_mismatch("status", 32'(rsp_if.status), 32'(want.status));
          if (rsp_if.value_out !== want.value_out)
            report_mismatch("value_out", rsp_if.value_out, want.value_out);
          if (rsp_if.last !== want.last)
            report_mismatch("last", 32'(rsp_if.last), 32'(want.last));
          if (rsp_if.entry_count !== want.entry_count)
            report_mismatch("entry_count", 32'(rsp_if.entry_count),
                            32'(want.entry_count));
        end
      end
      if (req_if.valid && req_if.ready) begin
        predict_queue_request(req_if.req_type, req_if.item_value);
      end
    end
  end

  // receiver: changing stall patterns, plus a long hold when asked
  initial begin : result_receiver
    int mode;
    int mode_left;
    int hold_left;
    int hold_served;
    int phase;
    mode        = 0;
    mode_left   = 0;
    hold_left   = 0;
    hold_served = 0;
    phase       = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = HoldCycles;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        case (mode)
          0:       rsp_if.ready <= 1'b1;
          1:       rsp_if.ready <= 1'($urandom_range(0, 1));
          2:       rsp_if.ready <= (phase % 3 == 0);
          default: rsp_if.ready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  // watchdog on cycles without any handshake
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WatchdogLimit) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle = 0;
      else idle++;
    end
    $display("[%0t] watchdog: no handshake for %0d cycles", $time, WatchdogLimit);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // sends one request, in bursts with random gaps between them
  task automatic send_request(input logic [1:0] kind, input logic [31:0] value);
    int gap;
    if (sender_idles && burst_left == 0) begin
      gap = $urandom_range(1, 5);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    req_if.valid      <= 1'b1;
    req_if.req_type   <= kind;
    req_if.item_value <= value;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // stop offering and wait for every predicted result
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // requests on an empty store
  task automatic test_empty_store();
    send_request(ReqDeq, 32'hDEAD_BEEF);
    send_request(ReqIter, 32'h0);
    send_request(ReqDel, 32'h0000_0005);
    send_request(ReqDel, 32'h0);
    wait_drained();
  endtask

  // fill to the brim, overflow, zero value and a full iterate
  task automatic test_full_store();
    logic [31:0] value;
    for (int i = 0; i < Depth; i++) begin
      case (i)
        0:       value = 32'hFFFF_FFFF;
        3, 10:   value = 32'hA5A5_5A5A;
        7:       value = 32'h8000_0000;
        8:       value = 32'h7FFF_FFFF;
        15:      value = 32'h0000_0001;
        default: value = $urandom | 32'h1;
      endcase
      send_request(ReqEnq, value);
    end
    send_request(ReqEnq, 32'h7777_7777);
    send_request(ReqEnq, 32'h0);
    send_request(ReqIter, 32'h0);
    wait_drained();
  endtask

  // duplicate delete takes the oldest match, then a dequeue from the head
  task automatic test_delete_cases();
    send_request(ReqDel, 32'hA5A5_5A5A);
    send_request(ReqDeq, 32'h0);
    wait_drained();
  endtask

  // receiver holds off while requests keep coming, so the input stalls
  task automatic test_output_stall();
    hold_requests++;
    for (int k = 0; k < 20; k++) begin
      send_request((k % 5 == 4) ? ReqIter : ReqEnq, $urandom | 32'h1);
    end
    wait_drained();
  endtask

  // mostly well-formed traffic on a small value pool, with some noise
  task automatic test_random_traffic(input int n_items);
    int          roll;
    int          enq_weight;
    int          idx;
    logic [1:0]  kind;
    logic [31:0] value;
    for (int p = 0; p < 8; p++) begin
      value_pool[p] = $urandom | 32'h1;
    end
    for (int k = 0; k < n_items; k++) begin
      if (k % 40 == 0) sender_idles = ($urandom_range(0, 3) != 0);
      if (k == n_items / 2) wait_drained();
      roll  = $urandom_range(0, 99);
      value = $urandom;
      if (roll < 5) begin
        // noise: any request, zero value half the time
        kind = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 1)) value = '0;
      end else begin
        enq_weight = (q_count >= Depth) ? 15 : (q_count < 4) ? 65 : 40;
        roll = $urandom_range(0, 99);
        if (roll < enq_weight) begin
          kind = ReqEnq;
          if ($urandom_range(0, 1)) value = value_pool[$urandom_range(0, 7)];
          if (value == '0) value = 32'h1;
        end else if (roll < enq_weight + (100 - enq_weight) * 2 / 5) begin
          kind = ReqDeq;
        end else if (roll < enq_weight + (100 - enq_weight) * 4 / 5) begin
          kind = ReqDel;
          if (q_count != 0 && $urandom_range(0, 9) < 6) begin
            idx   = $urandom_range(0, q_count - 1);
            value = queue_mem[(q_head + idx) % Depth];
          end else if ($urandom_range(0, 1)) begin
            value = value_pool[$urandom_range(0, 7)];
          end
          if (value == '0) value = 32'h1;
        end else begin
          kind = ReqIter;
        end
      end
      send_request(kind, value);
    end
    wait_drained();
  endtask

  // reset, tests in turn, drain and verdict
  initial begin : stimulus
    for (int i = 0; i < 4; i++) requests_seen[i] = 0;
    rst_ni            <= 1'b0;
    req_if.valid      <= 1'b0;
    req_if.req_type   <= ReqEnq;
    req_if.item_value <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_store();
    test_full_store();
    test_delete_cases();
    test_output_stall();
    test_random_traffic(155);

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Summary: %0d requests (enqueue %0d, dequeue %0d, delete %0d, iterate %0d), %0d results compared",
             requests_seen[ReqEnq] + requests_seen[ReqDeq] + requests_seen[ReqDel]
             + requests_seen[ReqIter], requests_seen[ReqEnq], requests_seen[ReqDeq],
             requests_seen[ReqDel], requests_seen[ReqIter], results_checked);
    $display("Summary: empty and full store, zero values, duplicate deletes, head wrap, %0d-cycle output hold",
             HoldCycles);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
